### rtl/xtd_pkg.sv
`default_nettype none

package xtd_pkg;

    localparam int WORD_W      = 32;
    localparam int KEY_WORDS   = 4;
    localparam int CFG_INDEX_W = 3;

    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9e37_79b9;

    // register indexes of the key words
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD0_IDX = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD1_IDX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD2_IDX = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD3_IDX = 3'd3;

    // one block in flight; keyed low means pass through unchanged
    typedef struct packed {
        logic              keyed;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } block_t;

    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] v);
        mix_word = ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

### rtl/xtd_half.sv
`default_nettype none

// one half round: dst -= mix(src) ^ (sum + key) when the block is keyed, registered
module xtd_half (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        upd_v0,
    input  wire logic [xtd_pkg::WORD_W-1:0]  sum,
    input  wire logic [xtd_pkg::WORD_W-1:0]  key,
    input  wire logic                        in_valid,
    input  wire xtd_pkg::block_t             in_blk,
    output logic                             valid_reg,
    output xtd_pkg::block_t                  blk_reg
);

    logic [xtd_pkg::WORD_W-1:0] src;
    logic [xtd_pkg::WORD_W-1:0] dst;
    logic [xtd_pkg::WORD_W-1:0] dst_new;
    xtd_pkg::block_t            blk_next;

    always_comb
    begin
        src      = upd_v0 ? in_blk.v1 : in_blk.v0;
        dst      = upd_v0 ? in_blk.v0 : in_blk.v1;
        dst_new  = dst - (xtd_pkg::mix_word(src) ^ (sum + key));
        blk_next = in_blk;
        if (in_blk.keyed)
        begin
            if (upd_v0)
            begin
                blk_next.v0 = dst_new;
            end
            else
            begin
                blk_next.v1 = dst_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            blk_reg <= blk_next;
        end
    end

endmodule

`default_nettype wire

### rtl/xtd_skid.sv
`default_nettype none

// output side: last stage presented directly, skid register catches it on a stall
module xtd_skid (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        last_valid,
    input  wire xtd_pkg::block_t             last_blk,
    output logic                             adv,
    output logic                             skid_valid_reg,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [xtd_pkg::WORD_W-1:0]       out_v0,
    output logic [xtd_pkg::WORD_W-1:0]       out_v1
);

    xtd_pkg::block_t skid_blk_reg;

    assign adv       = !skid_valid_reg;
    assign out_valid = skid_valid_reg || last_valid;
    assign out_v0    = skid_valid_reg ? skid_blk_reg.v0 : last_blk.v0;
    assign out_v1    = skid_valid_reg ? skid_blk_reg.v1 : last_blk.v1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (last_valid && !out_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_blk_reg <= last_blk;
        end
    end

endmodule

`default_nettype wire

### rtl/xtea_block_decrypt.sv
`default_nettype none

// XTEA block decryptor. Each input transfer carries one 64-bit ciphertext
// block as two big-endian words; each output transfer carries the decrypted
// pair. The datapath is a pipeline of 2*ROUNDS register stages, one stage per
// half round (one subtract of the mixed, key-added word); one block per cycle
// is sustained while the output is taken. The round sums and key word
// selection are fixed per stage at elaboration.
// On an output stall the final stage spills into a one-entry skid register;
// in_ready drops only while that register is full, so in_ready never depends
// combinationally on out_ready. The key is four 32-bit words written through
// cfg_write/cfg_index/cfg_data; writes to indexes above three are ignored.
// The key is sampled by the stages in flight, so change it only when the
// pipeline is empty. With an all-zero key a block passes through unchanged,
// with the same latency.
module xtea_block_decrypt #(
    parameter int ROUNDS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_write,
    input  wire logic [xtd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [xtd_pkg::WORD_W-1:0]       cfg_data,

    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [xtd_pkg::WORD_W-1:0]       cipher_first,
    input  wire logic [xtd_pkg::WORD_W-1:0]       cipher_second,

    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [xtd_pkg::WORD_W-1:0]            plain_first,
    output logic [xtd_pkg::WORD_W-1:0]            plain_second
);

    localparam int STAGES = 2 * ROUNDS;

    // key words
    logic [xtd_pkg::WORD_W-1:0] key_reg [xtd_pkg::KEY_WORDS];
    logic                       keyed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < xtd_pkg::KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                xtd_pkg::KEY_WORD0_IDX: key_reg[0] <= cfg_data;
                xtd_pkg::KEY_WORD1_IDX: key_reg[1] <= cfg_data;
                xtd_pkg::KEY_WORD2_IDX: key_reg[2] <= cfg_data;
                xtd_pkg::KEY_WORD3_IDX: key_reg[3] <= cfg_data;
                default: ; // index beyond the key, write dropped
            endcase
        end
    end

    assign keyed = |{key_reg[0], key_reg[1], key_reg[2], key_reg[3]};

    // pipeline stage chain; element 0 is the input side
    logic            stg_valid [STAGES+1];
    xtd_pkg::block_t stg_blk   [STAGES+1];
    logic            adv;
    logic            skid_valid;

    assign in_ready        = adv;
    assign stg_valid[0]    = in_valid;
    assign stg_blk[0].keyed = keyed;
    assign stg_blk[0].v0   = cipher_first;
    assign stg_blk[0].v1   = cipher_second;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        // even stages update v1 with the round sum, odd stages v0 with the
        // sum after one delta has been taken off
        localparam int          STEPS_LEFT = ROUNDS - s / 2 - s % 2;
        localparam logic [63:0] SUM_WIDE   =
            64'(xtd_pkg::XTEA_DELTA) * 64'(STEPS_LEFT);
        localparam logic [xtd_pkg::WORD_W-1:0] SUM = SUM_WIDE[xtd_pkg::WORD_W-1:0];
        localparam logic [1:0]  KEY_SEL    = (s % 2 == 0) ? SUM[12:11] : SUM[1:0];

        xtd_half u_half (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .upd_v0    (s % 2 == 1),
            .sum       (SUM),
            .key       (key_reg[KEY_SEL]),
            .in_valid  (stg_valid[s]),
            .in_blk    (stg_blk[s]),
            .valid_reg (stg_valid[s+1]),
            .blk_reg   (stg_blk[s+1])
        );
    end

    xtd_skid u_skid (
        .clk            (clk),
        .rst_n          (rst_n),
        .last_valid     (stg_valid[STAGES]),
        .last_blk       (stg_blk[STAGES]),
        .adv            (adv),
        .skid_valid_reg (skid_valid),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_v0         (plain_first),
        .out_v1         (plain_second)
    );

    // a held-off input means a result is waiting at the output
    a_stall_has_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid
    ) else $error("input held off with no result at the output");

    // the skid register fills only from a refused output transfer
    a_skid_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(skid_valid) |-> $past(out_valid && !out_ready)
    ) else $error("skid register filled without an output stall");

    // while stalled, the pipeline exit holds its item
    a_exit_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!in_ready && stg_valid[STAGES]) |=> stg_valid[STAGES]
    ) else $error("pipeline exit lost an item during a stall");

endmodule

`default_nettype wire
